>>> hdl/bffa_pkg.sv
// Shared types, constants and helper functions for the bitmap first-free allocator.
// No dependencies; imported by bitmap_first_free_allocator_core and bffa_scan.
`default_nettype none

package bffa_pkg;

  localparam int unsigned BitmapBytesDef = 1024;
  localparam int unsigned WordW          = 64;
  localparam int unsigned BytesPerWord   = 8;
  localparam int unsigned OffW           = 6;
  localparam int unsigned IdxW           = 13;
  localparam int unsigned RangeW         = 14;

  localparam logic [7:0] ByteFull = 8'hFF;

  localparam logic OpMark = 1'b0;
  localparam logic OpSeek = 1'b1;

  typedef struct packed {
    logic            hit;
    logic [OffW-1:0] off;
  } scan_res_t;

  // position of the first zero bit, counted MSB first
  function automatic logic [2:0] first_zero(input logic [7:0] v);
    logic [2:0] pos;
    pos = 3'd7;
    for (int k = 7; k >= 0; k--) begin
      if (!v[7-k]) begin
        pos = 3'(k);
      end
    end
    return pos;
  endfunction

endpackage

`default_nettype wire

>>> hdl/bitmap_first_free_allocator_core.sv
// Bitmap first-free allocator, top level: sequencer, word store and word checker.
// Depends on bffa_pkg, bffa_mem and bffa_scan.
//
// Input channel (in_valid_i / in_stall_o) takes one transaction: a mark sets or
// clears one bitmap bit, a seek looks for the first zero bit in a byte range.
// Every transaction yields one result on the output channel (out_valid_o /
// out_stall_i): found_o and free_index_o, both zero for a mark.
// The bitmap sits in 64-bit memory words, eight bytes each, with a registered read.
// A mark is a read-modify-write: the word is read, then written back changed.
// A seek issues one word read per cycle over the words of its range and stops at
// the first word holding a free bit. One transaction is in flight at a time.
// After reset the block sweeps zeros through the store, one word per cycle, with
// in_stall_o high. The result sits in an output register; a stalled result holds,
// and the next transaction is accepted while it waits.
`default_nettype none

module bitmap_first_free_allocator_core #(
  parameter int unsigned BITMAP_BYTES = bffa_pkg::BitmapBytesDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic                          opcode_i,
  input  wire logic [bffa_pkg::IdxW-1:0]     bit_index_i,
  input  wire logic                          set_value_i,
  input  wire logic [bffa_pkg::RangeW-1:0]   search_begin_i,
  input  wire logic [bffa_pkg::RangeW-1:0]   search_end_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic                               found_o,
  output logic [bffa_pkg::IdxW-1:0]          free_index_o
);
  import bffa_pkg::*;

  localparam int unsigned Words  = (BITMAP_BYTES + BytesPerWord - 1) / BytesPerWord;
  localparam int unsigned AddrW  = (Words > 1) ? $clog2(Words) : 1;
  localparam int unsigned ByteBW = $clog2(BITMAP_BYTES + 1);
  localparam int unsigned CntW   = (ByteBW > 11) ? ByteBW : 11;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_MWR   = 6'b000100,
    S_SEEK  = 6'b001000,
    S_RESP  = 6'b010000,
    S_MWAIT = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [AddrW-1:0]  clr_w_q, clr_w_d;
  logic [IdxW-1:0]   bit_q, bit_d;
  logic              set_q, set_d;
  logic [CntW-1:0]   beg_q, beg_d;
  logic [CntW-1:0]   end_q, end_d;
  logic [AddrW:0]    nxt_w_q, nxt_w_d;
  logic [AddrW-1:0]  chk_w_q, chk_w_d;
  logic              chk_vld_q, chk_vld_d;
  logic              res_found_q, res_found_d;
  logic [IdxW-1:0]   res_idx_q, res_idx_d;
  logic              out_vld_q, out_vld_d;
  logic              found_q, found_d;
  logic [IdxW-1:0]   free_idx_q, free_idx_d;

  logic              mem_we, mem_re;
  logic [AddrW-1:0]  mem_waddr, mem_raddr;
  logic [WordW-1:0]  mem_wdata, mem_rdata;
  scan_res_t         scan_res;

  logic              in_acc;
  logic [CntW-1:0]   in_beg, in_end_raw, in_end;
  logic              mark_ok;
  logic [CntW-1:0]   end_m1;
  logic [AddrW-1:0]  last_w;
  logic [OffW-1:0]   mark_pos;
  logic [WordW-1:0]  mark_word;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  assign in_beg     = CntW'(search_begin_i[RangeW-1:3]);
  assign in_end_raw = CntW'(search_end_i[RangeW-1:3]);
  assign in_end     = (in_end_raw > CntW'(BITMAP_BYTES)) ? CntW'(BITMAP_BYTES) : in_end_raw;
  assign mark_ok    = CntW'(bit_index_i[IdxW-1:3]) < CntW'(BITMAP_BYTES);

  assign end_m1 = end_q - CntW'(1);
  assign last_w = AddrW'(end_m1[CntW-1:3]);

  assign mark_pos = {bit_q[5:3], ~bit_q[2:0]};
  always_comb begin
    mark_word           = mem_rdata;
    mark_word[mark_pos] = set_q;
  end

  bffa_mem #(
    .Depth (Words),
    .AddrW (AddrW),
    .DataW (WordW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  bffa_scan #(
    .AddrW (AddrW),
    .CntW  (CntW)
  ) u_scan (
    .word_i     (mem_rdata),
    .word_idx_i (chk_w_q),
    .begin_i    (beg_q),
    .end_i      (end_q),
    .res_o      (scan_res)
  );

  always_comb begin
    state_d     = state_q;
    clr_w_d     = clr_w_q;
    bit_d       = bit_q;
    set_d       = set_q;
    beg_d       = beg_q;
    end_d       = end_q;
    nxt_w_d     = nxt_w_q;
    chk_w_d     = chk_w_q;
    chk_vld_d   = 1'b0;
    res_found_d = res_found_q;
    res_idx_d   = res_idx_q;
    mem_we      = 1'b0;
    mem_waddr   = AddrW'(bit_q[IdxW-1:6]);
    mem_wdata   = mark_word;
    mem_re      = 1'b0;
    mem_raddr   = nxt_w_q[AddrW-1:0];

    case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_w_q;
        mem_wdata = '0;
        clr_w_d   = clr_w_q + AddrW'(1);
        if (clr_w_q == AddrW'(Words - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          bit_d       = bit_index_i;
          set_d       = set_value_i;
          beg_d       = in_beg;
          end_d       = in_end;
          nxt_w_d     = (AddrW + 1)'(in_beg[CntW-1:3]);
          res_found_d = 1'b0;
          res_idx_d   = '0;
          if (opcode_i == OpMark) begin
            if (mark_ok) begin
              mem_re    = 1'b1;
              mem_raddr = AddrW'(bit_index_i[IdxW-1:6]);
              state_d   = S_MWR;
            end else begin
              state_d = S_RESP;
            end
          end else if (in_beg < in_end) begin
            state_d = S_SEEK;
          end else begin
            state_d = S_RESP;
          end
        end
      end
      S_MWR: begin
        state_d = S_MWAIT;
      end
      S_MWAIT: begin
        mem_we  = 1'b1;
        state_d = S_RESP;
      end
      S_SEEK: begin
        if (chk_vld_q && scan_res.hit) begin
          res_found_d = 1'b1;
          res_idx_d   = IdxW'({chk_w_q, scan_res.off});
          state_d     = S_RESP;
        end else if (nxt_w_q <= {1'b0, last_w}) begin
          mem_re    = 1'b1;
          chk_vld_d = 1'b1;
          chk_w_d   = nxt_w_q[AddrW-1:0];
          nxt_w_d   = nxt_w_q + (AddrW + 1)'(1);
        end else begin
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_vld_q || !out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_vld_d  = out_vld_q && out_stall_i;
    found_d    = found_q;
    free_idx_d = free_idx_q;
    if (state_q == S_RESP && (!out_vld_q || !out_stall_i)) begin
      out_vld_d  = 1'b1;
      found_d    = res_found_q;
      free_idx_d = res_idx_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      clr_w_q   <= '0;
      chk_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_w_q   <= clr_w_d;
      chk_vld_q <= chk_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bit_q       <= bit_d;
    set_q       <= set_d;
    beg_q       <= beg_d;
    end_q       <= end_d;
    nxt_w_q     <= nxt_w_d;
    chk_w_q     <= chk_w_d;
    res_found_q <= res_found_d;
    res_idx_q   <= res_idx_d;
    found_q     <= found_d;
    free_idx_q  <= free_idx_d;
  end

  assign out_valid_o  = out_vld_q;
  assign found_o      = found_q;
  assign free_index_o = free_idx_q;

  a_acc_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q != S_IDLE)
    else $error("accepted transaction did not start work");

  a_no_write_in_seek: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SEEK |-> !mem_we)
    else $error("bitmap written during seek");

  a_chk_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SEEK && chk_vld_q) |-> chk_w_q <= last_w)
    else $error("checked word beyond seek range");

  a_not_found_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !found_q) |-> free_idx_q == '0)
    else $error("nonzero index without a free bit");

  a_clear_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR && clr_w_q == AddrW'(Words - 1)) |=> state_q == S_IDLE)
    else $error("clearing sweep did not finish");

endmodule

`default_nettype wire

>>> hdl/bffa_mem.sv
// Bitmap word store: one write port, one registered read port.
// Depends on nothing beyond its parameters.
`default_nettype none

module bffa_mem #(
  parameter int unsigned Depth = 128,
  parameter int unsigned AddrW = 7,
  parameter int unsigned DataW = 64
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [DataW-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> hdl/bffa_scan.sv
// Word checker: finds the first free bit of a 64-bit bitmap word inside a byte range.
// Depends on bffa_pkg.
`default_nettype none

module bffa_scan #(
  parameter int unsigned AddrW = 7,
  parameter int unsigned CntW  = 11
) (
  input  wire logic [bffa_pkg::WordW-1:0] word_i,
  input  wire logic [AddrW-1:0]           word_idx_i,
  input  wire logic [CntW-1:0]            begin_i,
  input  wire logic [CntW-1:0]            end_i,
  output bffa_pkg::scan_res_t             res_o
);
  import bffa_pkg::*;

  logic [BytesPerWord-1:0] not_full;
  logic [2:0]              pos [BytesPerWord];

  always_comb begin
    for (int j = 0; j < BytesPerWord; j++) begin
      logic [CntW-1:0] addr;
      addr        = CntW'({word_idx_i, 3'(j)});
      not_full[j] = (addr >= begin_i) && (addr < end_i) && (word_i[8*j +: 8] != ByteFull);
      pos[j]      = first_zero(word_i[8*j +: 8]);
    end
  end

  always_comb begin
    res_o.hit = |not_full;
    res_o.off = '0;
    for (int j = BytesPerWord - 1; j >= 0; j--) begin
      if (not_full[j]) begin
        res_o.off = {3'(j), pos[j]};
      end
    end
  end

endmodule

`default_nettype wire
